FILE: rtl/spre_pkg.sv
// Shared types and constants of the smoothed pose rate estimator.
`default_nettype none
package spre_pkg;
    localparam int unsigned DataW = 32;
    localparam int unsigned GainW = 17;
    localparam int unsigned PeriodW = 20;
    localparam int unsigned TableLen = 24;
    localparam logic [16:0] GainOne = 17'd65536;
    localparam logic [16:0] GainReset = 17'd32768;
    localparam logic [19:0] PeriodReset = 20'd10000;
    localparam logic [19:0] RateScale = 20'd1000000;
    localparam logic [35:0] PiQ30 = 36'd3373259426;

    typedef enum logic [1:0] {
        ST_SEEDED  = 2'd0,
        ST_REPEAT  = 2'd1,
        ST_UPDATED = 2'd2
    } t_status;

    localparam logic [0:0] CFG_GAIN = 1'b0;
    localparam logic [0:0] CFG_PERIOD = 1'b1;

    // Arctangent of 2^-i in Q30.
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                5'd0: v = 32'd843314857;
                5'd1: v = 32'd497837829;
                5'd2: v = 32'd263043836;
                5'd3: v = 32'd133525158;
                5'd4: v = 32'd67021686;
                5'd5: v = 32'd33543515;
                5'd6: v = 32'd16775850;
                5'd7: v = 32'd8388437;
                5'd8: v = 32'd4194282;
                5'd9: v = 32'd2097149;
                5'd10: v = 32'd1048575;
                5'd11: v = 32'd524287;
                5'd12: v = 32'd262143;
                5'd13: v = 32'd131071;
                5'd14: v = 32'd65535;
                5'd15: v = 32'd32767;
                5'd16: v = 32'd16383;
                5'd17: v = 32'd8191;
                5'd18: v = 32'd4095;
                5'd19: v = 32'd2047;
                5'd20: v = 32'd1024;
                5'd21: v = 32'd512;
                5'd22: v = 32'd256;
                5'd23: v = 32'd128;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction
endpackage
`default_nettype wire

FILE: rtl/spre_cordic.sv
// Vectoring CORDIC that turns a quaternion into a heading, one rotation per cycle.
`default_nettype none
module spre_cordic #(
    parameter int unsigned FRAC_BITS = 16,
    parameter int unsigned ANGLE_ITERATIONS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [15:0] i_qx,
    input  wire logic [15:0] i_qy,
    input  wire logic [15:0] i_qz,
    input  wire logic [15:0] i_qw,
    output logic             o_done,
    output logic [31:0]      o_yaw
);
    import spre_pkg::*;

    localparam int unsigned Sh = 30 - FRAC_BITS;
    localparam logic [4:0] LastIter = 5'(ANGLE_ITERATIONS - 1);
    localparam logic signed [35:0] PiF =
        36'(($signed({1'b0, PiQ30}) + (64'sd1 <<< (Sh - 1))) >>> Sh);
    localparam logic signed [35:0] HalfPiF =
        36'(($signed({1'b0, PiQ30 >> 1}) + (64'sd1 <<< (Sh - 1))) >>> Sh);

    typedef enum logic [2:0] {S_IDLE, S_MUL0, S_MUL1, S_PRE, S_ITER, S_FIN} t_state;

    t_state r_state;
    logic signed [15:0] r_qx, r_qy, r_qz, r_qw;
    logic signed [35:0] r_x, r_y, r_z;
    logic [4:0] r_i;
    logic r_zero;

    logic signed [35:0] xs, ys, ang;
    logic signed [31:0] p_a, p_b;

    always_comb begin
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        ang = 36'(($signed({4'd0, atan_q30(r_i)}) + (36'sd1 <<< (Sh - 1))) >>> Sh);
        p_a = (r_state == S_MUL0) ? r_qw * r_qz : r_qw * r_qw;
        p_b = (r_state == S_MUL0) ? r_qx * r_qy : r_qx * r_qx;
    end

    // Products: w*z and x*y at MUL0; w, x, y and z squared at MUL1.
    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_qx <= i_qx; r_qy <= i_qy; r_qz <= i_qz; r_qw <= i_qw;
                        r_state <= S_MUL0;
                    end
                end
                S_MUL0: begin
                    r_y <= 36'(p_a) + 36'(p_b) + 36'(p_a) + 36'(p_b);
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_x <= 36'(p_a) + 36'(p_b) - 36'(r_qy * r_qy) - 36'(r_qz * r_qz);
                    r_state <= S_PRE;
                end
                S_PRE: begin
                    r_zero <= (r_x == 36'sd0) && (r_y == 36'sd0);
                    r_z <= 36'sd0;
                    r_i <= 5'd0;
                    if (r_x < 0) begin
                        if (r_y >= 0) begin
                            r_x <= r_y; r_y <= -r_x; r_z <= HalfPiF;
                        end else begin
                            r_x <= -r_y; r_y <= r_x; r_z <= -HalfPiF;
                        end
                    end
                    r_state <= S_ITER;
                end
                S_ITER: begin
                    if (r_y >= 0) begin
                        r_x <= r_x + ys; r_y <= r_y - xs; r_z <= r_z + ang;
                    end else begin
                        r_x <= r_x - ys; r_y <= r_y + xs; r_z <= r_z - ang;
                    end
                    r_i <= r_i + 5'd1;
                    if (r_i == LastIter) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (r_zero) o_yaw <= 32'd0;
                    else if (r_z > PiF || r_z <= -PiF) o_yaw <= 32'(PiF);
                    else o_yaw <= 32'(r_z);
                    o_done <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/spre_divider.sv
// Bit-serial rounded divider for rates: round(|n|*1e6/|d|), signed, saturated.
`default_nettype none
module spre_divider (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [33:0] i_num,
    input  wire logic signed [52:0] i_den,
    output logic                    o_done,
    output logic [31:0]             o_quot
);
    import spre_pkg::*;

    // Numerator scaled is below 2^54; denominator magnitude below 2^52.
    typedef enum logic [1:0] {D_IDLE, D_MUL, D_DIV, D_FIN} t_state;
    t_state r_state;
    logic [33:0] r_un;
    logic [52:0] r_ud;
    logic [53:0] r_ext;
    logic [53:0] r_rem;
    logic [53:0] r_q;
    logic [5:0] r_cnt;
    logic r_neg;
    logic [54:0] trial;

    // The scaled numerator gets half the divisor added, then a shift division
    // brings in one quotient bit a cycle.
    assign trial = {r_rem, r_ext[53]} - {2'b0, r_ud};

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_neg <= i_num[33] ^ i_den[52];
                        r_un <= i_num[33] ? 34'(-i_num) : 34'(i_num);
                        r_ud <= (i_den == 53'sd0) ? 53'd1
                              : (i_den[52] ? 53'(-i_den) : 53'(i_den));
                        r_state <= D_MUL;
                    end
                end
                D_MUL: begin
                    r_ext <= 54'(r_un) * 54'(RateScale) + 54'(r_ud >> 1);
                    r_rem <= 54'd0;
                    r_q <= 54'd0;
                    r_cnt <= 6'd0;
                    r_state <= D_DIV;
                end
                D_DIV: begin
                    if (!trial[54]) begin
                        r_rem <= trial[53:0];
                        r_q <= {r_q[52:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[52:0], r_ext[53]};
                        r_q <= {r_q[52:0], 1'b0};
                    end
                    r_ext <= {r_ext[52:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd53) r_state <= D_FIN;
                end
                D_FIN: begin
                    if (r_neg)
                        o_quot <= (r_q >= 54'd2147483648) ? 32'h8000_0000 : 32'(-r_q);
                    else
                        o_quot <= (r_q > 54'd2147483647) ? 32'h7FFF_FFFF : 32'(r_q);
                    o_done <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/smoothed_pose_rate_estimator.sv
// Top level: filter state, blend unit and the sequencer over the eleven channels.
// Usage: a sample is taken on i_valid/o_ready. The block works on one sample at a
// time. Yaw comes from a CORDIC; then each of the four positions runs blend, rate
// division and a second blend, and the three linear channels add a further
// division and blend. Each division is done by a bit-serial unit. Seeding and
// repeated frames skip the blends and divisions. The result is held in an
// output register until o_valid/i_ready completes the transaction; a new sample
// is taken only after that. Reset clears the state and sets gain 32768 and
// period 10000. Writing the period register over the configuration channel
// clears the filter state; a configuration write takes precedence over a sample
// offered in the same cycle.
`default_nettype none
module smoothed_pose_rate_estimator #(
    parameter int unsigned FRAC_BITS = 16,
    parameter int unsigned ANGLE_ITERATIONS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_pos_x,
    input  wire logic [31:0] i_pos_y,
    input  wire logic [31:0] i_pos_z,
    input  wire logic [15:0] i_quat_x,
    input  wire logic [15:0] i_quat_y,
    input  wire logic [15:0] i_quat_z,
    input  wire logic [15:0] i_quat_w,
    input  wire logic [31:0] i_frame_number,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_est_x,
    output logic [31:0]      o_est_y,
    output logic [31:0]      o_est_z,
    output logic [31:0]      o_est_yaw,
    output logic [31:0]      o_est_vx,
    output logic [31:0]      o_est_vy,
    output logic [31:0]      o_est_vz,
    output logic [31:0]      o_est_yaw_rate,
    output logic [31:0]      o_est_ax,
    output logic [31:0]      o_est_ay,
    output logic [31:0]      o_est_az,
    output logic [1:0]       o_update_status,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import spre_pkg::*;

    typedef enum logic [3:0] {
        T_IDLE, T_YAW, T_DECIDE, T_BP, T_RV, T_BV, T_RA, T_BA, T_NEXT, T_OUT
    } t_state;

    t_state r_state;
    logic [16:0] r_gain;
    logic [19:0] r_period;
    logic r_seeded;
    logic [31:0] r_last;
    logic [31:0] r_pos [4];
    logic [31:0] r_vel [4];
    logic [31:0] r_acc [3];
    logic [31:0] r_meas [4];
    logic [31:0] r_frame;
    logic [1:0] r_ch;
    logic [31:0] r_np, r_nv;
    logic signed [52:0] r_den;
    logic r_dstart;
    logic signed [33:0] r_dnum;
    logic [1:0] r_status;

    logic c_done, d_done;
    logic [31:0] c_yaw, d_q;
    logic in_accept;

    assign in_accept = i_valid && o_ready;

    // The CORDIC takes the quaternion straight from the ports at the accepting edge.
    spre_cordic #(.FRAC_BITS(FRAC_BITS), .ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(in_accept),
        .i_qx(i_quat_x), .i_qy(i_quat_y), .i_qz(i_quat_z), .i_qw(i_quat_w),
        .o_done(c_done), .o_yaw(c_yaw)
    );

    spre_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_dnum), .i_den(r_den), .o_done(d_done), .o_quot(d_q)
    );

    // Shared blend: g*old + (1-g)*meas, rounded half up.
    logic [31:0] bl_old, bl_meas, bl_res;
    logic [16:0] g;
    logic signed [50:0] bl_sum;
    always_comb begin
        g = (r_gain > GainOne) ? GainOne : r_gain;
        bl_sum = $signed({1'b0, g}) * $signed(bl_old)
               + $signed({1'b0, 17'(GainOne - g)}) * $signed(bl_meas) + 51'sd32768;
        bl_res = (bl_sum >>> 16) > 51'sd2147483647 ? 32'h7FFF_FFFF
               : (bl_sum >>> 16) < -51'sd2147483648 ? 32'h8000_0000
               : 32'(bl_sum >>> 16);
    end

    always_comb begin
        unique case (r_state)
            T_BP: begin bl_old = r_pos[r_ch]; bl_meas = r_meas[r_ch]; end
            T_BV: begin bl_old = r_vel[r_ch]; bl_meas = d_q; end
            default: begin bl_old = r_acc[r_ch[1:0] == 2'd3 ? 2'd0 : r_ch];
                bl_meas = d_q; end
        endcase
    end

    logic [31:0] fdelta;
    assign fdelta = i_frame_number - r_last;
    assign o_ready = i_rst_n && (r_state == T_IDLE) && !o_valid && !i_cfg_valid;
    assign o_cfg_ready = i_rst_n && (r_state == T_IDLE) && !o_valid;

    always_ff @(posedge i_clk) begin
        r_dstart <= 1'b0;
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            o_valid <= 1'b0;
            r_gain <= GainReset;
            r_period <= PeriodReset;
            r_seeded <= 1'b0;
            r_last <= 32'd0;
            for (int k = 0; k < 4; k++) begin r_pos[k] <= 32'd0; r_vel[k] <= 32'd0; end
            for (int k = 0; k < 3; k++) r_acc[k] <= 32'd0;
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_state)
                T_IDLE: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        if (i_cfg_index == CFG_GAIN) begin
                            r_gain <= i_cfg_data[16:0];
                        end else begin
                            r_period <= i_cfg_data[19:0];
                            r_seeded <= 1'b0;
                            r_last <= 32'd0;
                            for (int k = 0; k < 4; k++) begin
                                r_pos[k] <= 32'd0; r_vel[k] <= 32'd0;
                            end
                            for (int k = 0; k < 3; k++) r_acc[k] <= 32'd0;
                        end
                    end else if (in_accept) begin
                        r_meas[0] <= i_pos_x; r_meas[1] <= i_pos_y; r_meas[2] <= i_pos_z;
                        r_frame <= i_frame_number;
                        r_den <= $signed(fdelta) * $signed({1'b0,
                                 (r_period == 20'd0) ? 20'd1 : r_period});
                        r_state <= T_YAW;
                    end
                end
                T_YAW: if (c_done) begin r_meas[3] <= c_yaw; r_state <= T_DECIDE; end
                T_DECIDE: begin
                    r_ch <= 2'd0;
                    if (!r_seeded) begin
                        for (int k = 0; k < 4; k++) r_pos[k] <= r_meas[k];
                        r_last <= r_frame; r_seeded <= 1'b1;
                        r_status <= ST_SEEDED; r_state <= T_OUT;
                    end else if (r_frame == r_last) begin
                        r_status <= ST_REPEAT; r_state <= T_OUT;
                    end else begin
                        r_status <= ST_UPDATED; r_state <= T_BP;
                    end
                end
                T_BP: begin
                    r_np <= bl_res;
                    r_dnum <= 34'($signed(bl_res)) - 34'($signed(r_pos[r_ch]));
                    r_dstart <= 1'b1;
                    r_state <= T_RV;
                end
                T_RV: if (d_done) r_state <= T_BV;
                T_BV: begin
                    r_nv <= bl_res;
                    if (r_ch != 2'd3) begin
                        r_dnum <= 34'($signed(bl_res)) - 34'($signed(r_vel[r_ch]));
                        r_dstart <= 1'b1;
                        r_state <= T_RA;
                    end else r_state <= T_NEXT;
                end
                T_RA: if (d_done) r_state <= T_BA;
                T_BA: begin r_acc[r_ch] <= bl_res; r_state <= T_NEXT; end
                T_NEXT: begin
                    r_pos[r_ch] <= r_np; r_vel[r_ch] <= r_nv;
                    if (r_ch == 2'd3) begin r_last <= r_frame; r_state <= T_OUT; end
                    else begin r_ch <= r_ch + 2'd1; r_state <= T_BP; end
                end
                T_OUT: begin
                    o_est_x <= r_pos[0]; o_est_y <= r_pos[1]; o_est_z <= r_pos[2];
                    o_est_yaw <= r_pos[3];
                    o_est_vx <= r_vel[0]; o_est_vy <= r_vel[1]; o_est_vz <= r_vel[2];
                    o_est_yaw_rate <= r_vel[3];
                    o_est_ax <= r_acc[0]; o_est_ay <= r_acc[1]; o_est_az <= r_acc[2];
                    o_update_status <= r_status;
                    o_valid <= 1'b1;
                    r_state <= T_IDLE;
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_one_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("sample accepted while result pending");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_update_status != 2'd3)) else $error("bad status");
    a_cordic_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_done |-> (r_state == T_YAW)) else $error("stray heading result");
`endif
endmodule
`default_nettype wire

FILE: tb/tb_smoothed_pose_rate_estimator.sv
// Self-checking testbench of the smoothed pose rate estimator.
`timescale 1ns / 100ps
module tb_smoothed_pose_rate_estimator;
    import spre_pkg::*;

    typedef struct {
        logic [31:0] est [11];
        t_status     status;
    } t_pose_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic [15:0] i_quat_x, i_quat_y, i_quat_z, i_quat_w;
    logic [31:0] i_frame_number;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_est_x, o_est_y, o_est_z, o_est_yaw;
    logic [31:0] o_est_vx, o_est_vy, o_est_vz, o_est_yaw_rate;
    logic [31:0] o_est_ax, o_est_ay, o_est_az;
    logic [1:0]  o_update_status;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;

    smoothed_pose_rate_estimator dut (.*);

    // Filter copy kept alongside the block.
    logic [16:0]  gain_reg;
    logic [19:0]  period_reg;
    bit           est_seeded;
    logic [31:0]  est_last_frame;
    longint       est_pos [4];
    longint       est_vel [4];
    longint       est_acc [3];

    t_pose_result pending_poses [$];
    int           error_count;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_off_cycles;
    logic [31:0]  cur_frame;

    const string field_name [11] = '{"est_x", "est_y", "est_z", "est_yaw", "est_vx",
        "est_vy", "est_vz", "est_yaw_rate", "est_ax", "est_ay", "est_az"};
    const longint atan_table [16] = '{843314857, 497837829, 263043836, 133525158,
        67021686, 33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767};

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint q30_to_frac(longint v);
        return (v + (64'sd1 <<< 13)) >>> 14;
    endfunction

    function automatic longint smooth(longint prev, longint meas);
        longint g;
        g = (gain_reg > GainOne) ? 65536 : longint'(gain_reg);
        return sat_word((g * prev + (65536 - g) * meas + 32768) >>> 16);
    endfunction

    // Rate per second, rounded to nearest with ties away from zero.
    function automatic longint rate_per_s(longint diff, longint den);
        bit          neg;
        longint unsigned un, ud, q;
        neg = (diff < 0) != (den < 0);
        un = (diff < 0) ? -diff : diff;
        ud = (den < 0) ? -den : den;
        if (ud == 0) ud = 1;
        q = (un * 64'd1000000 + ud / 2) / ud;
        if (neg) return (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
        return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
    endfunction

    function automatic longint heading(longint qx, longint qy, longint qz, longint qw);
        longint x, y, z, t, xs, ys, pi_f;
        pi_f = q30_to_frac(longint'(PiQ30));
        y = 2 * (qw * qz + qx * qy);
        x = qw * qw + qx * qx - qy * qy - qz * qz;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = q30_to_frac(longint'(PiQ30) / 2);
            end else begin
                x = -y;
                y = t;
                z = -q30_to_frac(longint'(PiQ30) / 2);
            end
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + q30_to_frac(atan_table[i]);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - q30_to_frac(atan_table[i]);
            end
        end
        if (z > pi_f || z <= -pi_f) z = pi_f;
        return sat_word(z);
    endfunction

    function automatic void clear_filter();
        est_seeded = 0;
        est_last_frame = '0;
        foreach (est_pos[i]) est_pos[i] = 0;
        foreach (est_vel[i]) est_vel[i] = 0;
        foreach (est_acc[i]) est_acc[i] = 0;
    endfunction

    function automatic t_pose_result predict_pose(logic [31:0] px, logic [31:0] py,
        logic [31:0] pz, logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
        logic [15:0] qw, logic [31:0] frame);
        t_pose_result r;
        longint       meas [4];
        longint       sd, den, np, nv;
        meas[0] = longint'($signed(px));
        meas[1] = longint'($signed(py));
        meas[2] = longint'($signed(pz));
        meas[3] = heading($signed(qx), $signed(qy), $signed(qz), $signed(qw));
        if (!est_seeded) begin
            foreach (meas[i]) est_pos[i] = meas[i];
            est_last_frame = frame;
            est_seeded = 1;
            r.status = ST_SEEDED;
        end else if (frame == est_last_frame) begin
            r.status = ST_REPEAT;
        end else begin
            sd = longint'($signed(frame - est_last_frame));
            den = sd * ((period_reg == 0) ? 1 : longint'(period_reg));
            for (int i = 0; i < 4; i++) begin
                np = smooth(est_pos[i], meas[i]);
                nv = smooth(est_vel[i], rate_per_s(np - est_pos[i], den));
                if (i < 3) est_acc[i] = smooth(est_acc[i], rate_per_s(nv - est_vel[i], den));
                est_pos[i] = np;
                est_vel[i] = nv;
            end
            est_last_frame = frame;
            r.status = ST_UPDATED;
        end
        for (int i = 0; i < 4; i++) begin
            r.est[i] = est_pos[i][31:0];
            r.est[4 + i] = est_vel[i][31:0];
        end
        for (int i = 0; i < 3; i++) r.est[8 + i] = est_acc[i][31:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ERROR %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Receiver side: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            i_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_pose_result want;
        logic [31:0]  got [11];
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_est_x, o_est_y, o_est_z, o_est_yaw, o_est_vx, o_est_vy, o_est_vz,
                    o_est_yaw_rate, o_est_ax, o_est_ay, o_est_az};
            if (pending_poses.size() == 0) begin
                report_mismatch("unexpected result transaction", o_est_x, 32'h0);
            end else begin
                want = pending_poses.pop_front();
                for (int i = 0; i < 11; i++)
                    if (got[i] !== want.est[i]) report_mismatch(field_name[i], got[i], want.est[i]);
                if (o_update_status !== want.status)
                    report_mismatch("update_status", 32'(o_update_status), 32'(want.status));
            end
        end
    end

    task automatic send_sample(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
        logic [15:0] qx, logic [15:0] qy, logic [15:0] qz, logic [15:0] qw,
        logic [31:0] frame);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(12, 1) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pos_x <= px;
        i_pos_y <= py;
        i_pos_z <= pz;
        i_quat_x <= qx;
        i_quat_y <= qy;
        i_quat_z <= qz;
        i_quat_w <= qw;
        i_frame_number <= frame;
        do @(posedge i_clk); while (!o_ready);
        pending_poses.push_back(predict_pose(px, py, pz, qx, qy, qz, qw, frame));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_poses.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [31:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_GAIN) begin
            gain_reg = data[16:0];
        end else begin
            period_reg = data[19:0];
            clear_filter();
        end
    endtask

    task automatic send_random_sample(bit wild);
        logic [31:0] p [3];
        int          pick;
        pick = $urandom_range(99);
        if (pick < 8) cur_frame = cur_frame;
        else if (pick < 12 || wild) cur_frame = $urandom;
        else if (pick < 16) cur_frame = cur_frame - $urandom_range(3, 1);
        else cur_frame = cur_frame + $urandom_range(3, 1);
        foreach (p[i]) p[i] = wild ? $urandom : 32'($signed($urandom_range(200000)) - 100000);
        send_sample(p[0], p[1], p[2], 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), cur_frame);
    endtask

    task automatic test_reset_defaults();
        cur_frame = 32'd100;
        send_sample(32'h0001_0000, 32'hFFFF_0000, 32'h0, 16'h0, 16'h0, 16'h0, 16'h7FFF,
                    cur_frame);
        send_sample(32'h0002_0000, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h7FFF, cur_frame);
        for (int i = 0; i < 3; i++) begin
            cur_frame = cur_frame + 1;
            send_sample(32'h0002_0000 * i, 32'h8000, -32'sd65536 * i, 16'h0, 16'h0,
                        16'(16'h2000 * i), 16'h7000, cur_frame);
        end
    endtask

    task automatic test_special_cases();
        // Zero quaternion, left half-plane both sides, headings near pi and near zero.
        send_sample(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, cur_frame + 1);
        send_sample(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h7FFF, 16'h0, cur_frame + 2);
        send_sample(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h7FFF, 16'hC000, cur_frame + 3);
        send_sample(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h7FFF, 16'h4000, cur_frame + 4);
        send_sample(32'h0, 32'h0, 32'h0, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                    cur_frame + 5);
        send_sample(32'h0, 32'h0, 32'h0, 16'h7FFF, 16'h0001, 16'h0, 16'h0, cur_frame + 6);
        send_sample(32'h0, 32'h0, 32'h0, 16'h7FFF, 16'hFFFF, 16'h0, 16'h0, cur_frame + 7);
        // A negative frame step, then a step across the wrap of the frame counter.
        send_sample(32'h0010_0000, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h7FFF,
                    cur_frame + 2);
        send_sample(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h7FFF, 32'hFFFF_FFFF);
        send_sample(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h7FFF, 32'h0000_0001);
        cur_frame = 32'h1;
    endtask

    task automatic test_extremes();
        write_cfg(CFG_PERIOD, 32'd1);
        write_cfg(CFG_GAIN, 32'd0);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 16'h7FFF,
                    16'h8000, 16'h7FFF, 32'h0);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 16'h8000,
                    16'h7FFF, 16'h8000, 32'h1);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'h0, 16'h0, 16'h0, 16'h7FFF,
                    32'h2);
        send_sample(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 16'h0, 16'h0, 16'h0, 16'h7FFF,
                    32'h8000_0002);
        cur_frame = 32'h8000_0002;
    endtask

    task automatic test_config_extremes();
        int gains [4] = '{65536, 131071, 1, 32'hFFFF_FFFF};
        int periods [4] = '{0, 1000000, 32'hFFF0_FFFF, 32'h000F_FFFF};
        for (int k = 0; k < 4; k++) begin
            write_cfg(CFG_GAIN, gains[k]);
            write_cfg(CFG_PERIOD, periods[k]);
            cur_frame = $urandom;
            repeat (6) send_random_sample(k[0]);
        end
    endtask

    task automatic test_random_phases();
        int idle_mode [4][2] = '{'{0, 0}, '{85, 0}, '{0, 85}, '{35, 35}};
        for (int ph = 0; ph < 8; ph++) begin
            send_idle_pct = idle_mode[ph % 4][0];
            recv_stall_pct = idle_mode[ph % 4][1];
            write_cfg(CFG_GAIN, $urandom_range(65536));
            if (ph % 2 == 0) write_cfg(CFG_PERIOD, $urandom_range(20000, 1));
            repeat (50) send_random_sample($urandom_range(9) == 0);
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles <= 3000;
        repeat (6) send_random_sample(0);
        // Sender pauses until every result has been collected.
        wait_drained();
        repeat (6) send_random_sample(0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_pos_z = '0;
        i_quat_x = '0;
        i_quat_y = '0;
        i_quat_z = '0;
        i_quat_w = '0;
        i_frame_number = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_GAIN;
        i_cfg_data = '0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        gain_reg = GainReset;
        period_reg = PeriodReset;
        clear_filter();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_special_cases();
        test_extremes();
        test_config_extremes();
        test_random_phases();
        test_backpressure();
        wait_drained();
        repeat (500) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_smoothed_pose_rate_estimator: PASS");
        end else begin
            $display("tb_smoothed_pose_rate_estimator: FAIL");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("tb_smoothed_pose_rate_estimator: FAIL");
        $finish;
    end
endmodule

FILE: smoothed_pose_rate_estimator.f
rtl/spre_pkg.sv
rtl/spre_cordic.sv
rtl/spre_divider.sv
rtl/smoothed_pose_rate_estimator.sv
tb/tb_smoothed_pose_rate_estimator.sv
